// File: sv/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// shared constants and codes of the histogram peak estimator
// ----------------------------------------------------------------------------
package hpe_pkg;

    localparam int NrBins    = 64;
    localparam int BinBits   = $clog2(NrBins);
    localparam int CountBits = 24;
    localparam int HatBits   = 16;
    localparam int MassBits  = 30;
    localparam int WBits     = 8;
    localparam int WsumBits  = WBits + 2;
    localparam int SumBits   = CountBits + WBits + 2;
    localparam int CfgBits   = 24;
    localparam int CfgIdxBits = 3;

    typedef enum logic [1:0] {
        K_SAMPLE = 2'd0,
        K_ESTIMATE = 2'd1,
        K_HAT = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_LOW_MASS = 2'd1,
        ST_SHAPE = 2'd2
    } t_status;

    localparam logic [CfgIdxBits-1:0] REG_WL    = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_WC    = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_WR    = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_LIMIT = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_DECAY = 3'd4;

endpackage

// File: sv/histogram_peak_estimator.sv
// ----------------------------------------------------------------------------
// histogram_peak_estimator
// 64-bin count histogram with smoothed peak search, shape check and decay
// ----------------------------------------------------------------------------
// channel  | direction | signals
// request  | in        | i_valid, o_stall, i_kind, i_bin_index, i_hat_value
// result   | out       | o_valid, i_stall, o_status, o_peak_bin, o_total_mass
// config   | in        | i_cfg_we, i_cfg_index, i_cfg_data
//
// sample requests do a memory read, then a write back; hat requests a single write
// clear runs over all NrBins bins, one bin per cycle
// estimate: smoothing reads three taps per bin one by one and divides their
// weighted sum bit-serially, then a peak/mass scan, a shape scan and a decay
// pass each run over all bins; the shape scan runs only when the mass reaches
// the limit, and the decay pass only when the shape check passes
// after reset the block runs a clearing pass over all bins before o_stall drops
// a result waits in an output register; a finished estimate holds o_stall only
// while that register is still stalled
module histogram_peak_estimator
    import hpe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_kind,
    input  logic [5:0]             i_bin_index,
    input  logic [15:0]            i_hat_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic [5:0]             o_peak_bin,
    output logic [29:0]            o_total_mass,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_index,
    input  logic [CfgBits-1:0]     i_cfg_data
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_SMP_RD, S_SMP_WR, S_HAT_WR, S_CLR,
        S_SM_RD0, S_SM_RD1, S_SM_RD2, S_SM_MAC, S_SM_DIV, S_SM_WR,
        S_PK_RD, S_PK_ACC, S_PK_CHK, S_SH_RD, S_SH_MUL, S_SH_CMP,
        S_DC_RD, S_DC_MUL, S_DC_WR, S_OUT
    } t_state;

    logic [CountBits-1:0] r_bins [NrBins];
    logic [CountBits-1:0] r_smooth [NrBins];
    logic [HatBits-1:0]   r_hat [NrBins];

    t_state r_state;
    logic [WBits-1:0]    r_wl, r_wc, r_wr, r_decay;
    logic [CountBits-1:0] r_limit;
    logic [BinBits:0]    r_idx;
    logic [BinBits-1:0]  r_tap;
    logic [1:0]          r_tapn;
    logic [CountBits-1:0] r_bin_q, r_sm_q;
    logic [HatBits-1:0]  r_hat_q;
    logic [SumBits-1:0]  r_acc;
    logic [SumBits-1:0]  r_prod;
    logic [WsumBits-1:0] r_wsum;
    logic [SumBits-1:0]  r_rem;
    logic [SumBits-1:0]  r_quo;
    logic [5:0]          r_dcnt;
    logic [CountBits-1:0] r_best, r_pv;
    logic [BinBits-1:0]  r_peak;
    logic [MassBits:0]   r_mass;
    logic [1:0]          r_status;
    logic                r_bad;
    logic [BinBits-1:0]  r_bidx;
    logic [HatBits-1:0]  r_hval;
    logic [CountBits+HatBits-1:0] r_lhs, r_rhs;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [BinBits-1:0]  r_out_peak;
    logic [MassBits-1:0] r_out_mass;

    // memory port controls: bin write port, smooth write enable, one read address per array
    logic                 bin_we;
    logic [BinBits-1:0]   bin_wa;
    logic [CountBits-1:0] bin_wd;
    logic [BinBits-1:0]   bin_ra;
    logic                 sm_we;
    logic [BinBits-1:0]   sm_ra;
    logic [BinBits-1:0]   hat_ra;

    logic [BinBits-1:0]   idx_lo;
    logic                 last_bin;
    logic signed [BinBits+1:0] hat_pos;
    logic [SumBits:0]     rem_shift;
    logic [SumBits-1:0]   dsub;
    logic                 out_load;

    assign idx_lo   = r_idx[BinBits-1:0];
    assign last_bin = (idx_lo == BinBits'(NrBins - 1));
    assign hat_pos  = $signed({2'b00, idx_lo}) - $signed({2'b00, r_peak})
                      + $signed((BinBits+2)'(NrBins / 2));
    assign rem_shift = {r_rem, r_quo[SumBits-1]};
    assign dsub      = SumBits'(rem_shift) - SumBits'(r_wsum);
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        bin_ra = idx_lo;
        if (r_state == S_IDLE)
            bin_ra = i_bin_index;
        else if (r_state == S_SMP_RD)
            bin_ra = r_bidx;
        else if (r_state == S_SM_RD0 || r_state == S_SM_RD1 || r_state == S_SM_RD2)
            bin_ra = r_tap;
        else if (r_state == S_PK_CHK)
            bin_ra = r_peak;
        sm_ra  = idx_lo;
        hat_ra = hat_pos[BinBits-1:0];
        bin_we = 1'b0;
        bin_wa = idx_lo;
        bin_wd = '0;
        sm_we  = (r_state == S_SM_WR);
        unique case (r_state)
            S_INIT, S_CLR: begin
                bin_we = 1'b1;
            end
            S_SMP_WR: begin
                bin_we = 1'b1;
                bin_wa = r_bidx;
                bin_wd = r_bin_q + CountBits'(r_bin_q != {CountBits{1'b1}});
            end
            S_DC_WR: begin
                bin_we = 1'b1;
                bin_wd = r_prod[CountBits+7:8];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin_q <= r_bins[bin_ra];
        r_sm_q  <= r_smooth[sm_ra];
        r_hat_q <= r_hat[hat_ra];
        if (bin_we)
            r_bins[bin_wa] <= bin_wd;
        if (sm_we)
            r_smooth[idx_lo] <= r_quo[CountBits-1:0];
        if (r_state == S_HAT_WR)
            r_hat[r_bidx] <= r_hval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_wl        <= 8'd1;
            r_wc        <= 8'd2;
            r_wr        <= 8'd1;
            r_limit     <= 24'd100;
            r_decay     <= 8'd230;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WL:    r_wl    <= i_cfg_data[WBits-1:0];
                    REG_WC:    r_wc    <= i_cfg_data[WBits-1:0];
                    REG_WR:    r_wr    <= i_cfg_data[WBits-1:0];
                    REG_LIMIT: r_limit <= i_cfg_data;
                    REG_DECAY: r_decay <= i_cfg_data[WBits-1:0];
                    default: ;
                endcase
            end
            if (out_load)
                r_out_valid <= 1'b1;
            else if (!i_stall)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_INIT, S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (last_bin) begin
                        r_state <= S_IDLE;
                        r_idx   <= '0;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_bidx <= i_bin_index;
                        r_hval <= i_hat_value;
                        r_idx  <= '0;
                        unique case (t_kind'(i_kind))
                            K_SAMPLE:   r_state <= S_SMP_RD;
                            K_HAT:      r_state <= S_HAT_WR;
                            K_CLEAR:    r_state <= S_CLR;
                            K_ESTIMATE: begin
                                r_state <= S_SM_RD0;
                                r_tap   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SMP_RD: r_state <= S_SMP_WR;
                S_SMP_WR, S_HAT_WR: r_state <= S_IDLE;
                // three taps read one by one, product summed per tap
                S_SM_RD0: begin
                    r_acc  <= '0;
                    r_wsum <= '0;
                    r_tapn <= 2'd0;
                    r_tap  <= (idx_lo == '0) ? idx_lo : idx_lo - 1'b1;
                    r_state <= S_SM_RD1;
                end
                S_SM_RD1: r_state <= S_SM_RD2;
                S_SM_RD2: begin
                    // r_bin_q holds the value of the tap selected in r_tap
                    r_state <= S_SM_MAC;
                end
                S_SM_MAC: begin
                    logic [WBits-1:0] w;
                    logic use_tap;
                    logic [SumBits-1:0] prod;
                    w = (r_tapn == 2'd0) ? r_wl : (r_tapn == 2'd1) ? r_wc : r_wr;
                    use_tap = !((r_tapn == 2'd0 && idx_lo == '0) ||
                                (r_tapn == 2'd2 && last_bin));
                    prod = SumBits'(32'(r_bin_q) * 32'(w));
                    if (use_tap) begin
                        r_acc  <= r_acc + prod;
                        r_wsum <= r_wsum + WsumBits'(w);
                    end
                    if (r_tapn == 2'd2) begin
                        r_state <= S_SM_DIV;
                        r_dcnt  <= 6'(SumBits);
                        r_rem   <= '0;
                        r_quo   <= (use_tap) ? r_acc + prod : r_acc;
                    end else begin
                        r_tapn  <= r_tapn + 1'b1;
                        r_tap   <= (r_tapn == 2'd0) ? idx_lo :
                                   (last_bin ? idx_lo : idx_lo + 1'b1);
                        r_state <= S_SM_RD1;
                    end
                end
                S_SM_DIV: begin
                    if (r_wsum == '0) begin
                        r_quo   <= '0;
                        r_state <= S_SM_WR;
                    end else begin
                        if (rem_shift >= (SumBits+1)'(r_wsum)) begin
                            r_rem <= dsub;
                            r_quo <= {r_quo[SumBits-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_shift[SumBits-1:0];
                            r_quo <= {r_quo[SumBits-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt - 1'b1;
                        if (r_dcnt == 6'd1)
                            r_state <= S_SM_WR;
                    end
                end
                S_SM_WR: begin
                    r_idx <= r_idx + 1'b1;
                    if (last_bin) begin
                        r_idx   <= '0;
                        r_mass  <= '0;
                        r_best  <= '0;
                        r_peak  <= '0;
                        r_state <= S_PK_RD;
                    end else begin
                        r_state <= S_SM_RD0;
                    end
                end
                S_PK_RD: r_state <= S_PK_ACC;
                S_PK_ACC: begin
                    if (idx_lo == '0 || r_sm_q > r_best) begin
                        r_best <= r_sm_q;
                        r_peak <= idx_lo;
                    end
                    if (r_mass + (MassBits+1)'(r_sm_q) > (MassBits+1)'({MassBits{1'b1}}))
                        r_mass <= (MassBits+1)'({MassBits{1'b1}});
                    else
                        r_mass <= r_mass + (MassBits+1)'(r_sm_q);
                    r_idx <= r_idx + 1'b1;
                    if (last_bin) begin
                        r_idx   <= '0;
                        r_state <= S_PK_CHK;
                    end else begin
                        r_state <= S_PK_RD;
                    end
                end
                S_PK_CHK: begin
                    // bin_ra points at the peak; value lands next cycle
                    r_bad <= 1'b0;
                    if (r_mass < (MassBits+1)'(r_limit)) begin
                        r_status <= ST_LOW_MASS;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    if (r_idx == '0)
                        r_pv <= r_bin_q;
                    r_state <= S_SH_MUL;
                end
                S_SH_MUL: begin
                    r_lhs <= (CountBits+HatBits)'({r_bin_q, 12'b0});
                    r_rhs <= r_pv * r_hat_q;
                    r_state <= S_SH_CMP;
                end
                S_SH_CMP: begin
                    if (!hat_pos[BinBits+1] && !hat_pos[BinBits] && r_lhs > r_rhs)
                        r_bad <= 1'b1;
                    r_idx <= r_idx + 1'b1;
                    if (last_bin) begin
                        r_idx <= '0;
                        if (r_bad || (!hat_pos[BinBits+1] && !hat_pos[BinBits]
                                      && r_lhs > r_rhs)) begin
                            r_status <= ST_SHAPE;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_DC_RD;
                        end
                    end else begin
                        r_state <= S_SH_RD;
                    end
                end
                S_DC_RD: r_state <= S_DC_MUL;
                S_DC_MUL: begin
                    r_prod  <= SumBits'(32'(r_bin_q) * 32'(r_decay));
                    r_state <= S_DC_WR;
                end
                S_DC_WR: begin
                    r_idx <= r_idx + 1'b1;
                    if (last_bin) begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DC_RD;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_status <= r_status;
                        r_out_peak   <= r_peak;
                        r_out_mass   <= r_mass[MassBits-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_peak_bin   = r_out_peak;
    assign o_total_mass = r_out_mass;

endmodule

// File: sv/hpe_checker.sv
// ----------------------------------------------------------------------------
// hpe_checker
// port-level checks of the histogram peak estimator
// ----------------------------------------------------------------------------
module hpe_checker
    import hpe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [5:0]  o_peak_bin
);

    // a new result only follows a busy cycle
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)) else $error("result without busy cycle");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_LOW_MASS ||
                     o_status == ST_SHAPE)) else $error("bad status code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_peak_bin) && $stable(o_status))
        else $error("stalled result changed");

    // the block is busy right after a request was taken
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("not busy after request");

endmodule

bind histogram_peak_estimator hpe_checker u_hpe_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_peak_bin(o_peak_bin)
);
